>>> hw/rtl/scb_pkg.sv
// ----------------------------------------------------------------------------
// scb_pkg: shared definitions for the sprite cell blitter
// Command codes, register indexes, reset values and the per-item control word.
// ----------------------------------------------------------------------------
package scb_pkg;

	// Command codes carried by an input item.
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_BLIT  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 8;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_W = 8'd0,
		REG_FRAME_H = 8'd1
	} cfg_reg_t;

	// Field widths fixed by the item format.
	localparam int DIM_W  = 7;
	localparam int CELL_W = 2;

	localparam logic [CELL_W-1:0] CELL_EMPTY = 2'd0;

	localparam logic [DIM_W-1:0] RESET_FRAME_W = 7'd40;
	localparam logic [DIM_W-1:0] RESET_FRAME_H = 7'd30;

	// Default store geometry.
	localparam int MAX_FRAME_W_DEF = 64;
	localparam int MAX_FRAME_H_DEF = 64;

	// Decoded control word of one item, passed from the clipper down the pipe.
	typedef struct packed {
		logic is_clear;
		logic is_read;
		logic vis;
		logic wr_en;
	} op_t;

endpackage

>>> hw/rtl/scb_ifs.sv
// ----------------------------------------------------------------------------
// scb_ifs: channel interfaces of the sprite cell blitter
// Command channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------

// Command channel: one item per blit, read or clear.
interface scb_cmd_if;
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic signed [7:0] sprite_x;
	logic signed [7:0] sprite_y;
	logic [5:0]        cell_x;
	logic [5:0]        cell_y;
	logic [1:0]        cell_value;
	logic              is_opaque;

	modport source (
		output valid, command, sprite_x, sprite_y, cell_x, cell_y, cell_value, is_opaque,
		input  ready
	);
	modport sink (
		input  valid, command, sprite_x, sprite_y, cell_x, cell_y, cell_value, is_opaque,
		output ready
	);
endinterface

// Result channel: one item per command.
interface scb_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] read_value;
	logic       written;

	modport source (output valid, read_value, written, input ready);
	modport sink (input valid, read_value, written, output ready);
endinterface

// Configuration write channel.
interface scb_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [6:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/scb_frame_mem.sv
// ----------------------------------------------------------------------------
// scb_frame_mem: frame store
// One write port and one read port; read data is registered and holds its
// value until the next read.
// ----------------------------------------------------------------------------
module scb_frame_mem
	import scb_pkg::*;
#(
	parameter int DEPTH = MAX_FRAME_W_DEF * MAX_FRAME_H_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata
);

	logic [CELL_W-1:0] mem [DEPTH];
	logic [CELL_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/scb_clip.sv
// ----------------------------------------------------------------------------
// scb_clip: target cell and clipping
// Decodes a command item, forms the target column and row, checks them
// against the visible frame and builds the store address.
// ----------------------------------------------------------------------------
module scb_clip
	import scb_pkg::*;
#(
	parameter int MAX_FRAME_W = MAX_FRAME_W_DEF,
	parameter int MAX_FRAME_H = MAX_FRAME_H_DEF,
	parameter int AW          = $clog2(MAX_FRAME_W * MAX_FRAME_H)
) (
	input  logic [1:0]        command,
	input  logic signed [7:0] sprite_x,
	input  logic signed [7:0] sprite_y,
	input  logic [5:0]        cell_x,
	input  logic [5:0]        cell_y,
	input  logic [1:0]        cell_value,
	input  logic              is_opaque,
	input  logic [DIM_W-1:0]  frame_width,
	input  logic [DIM_W-1:0]  frame_height,
	output op_t               op,
	output logic [AW-1:0]     addr
);

	logic       is_blit;
	logic       is_read;
	logic       is_clear;
	logic [8:0] col;
	logic [8:0] row;
	logic       col_ok;
	logic       row_ok;

	// Command decode.
	always_comb begin
		is_blit  = 1'b0;
		is_read  = 1'b0;
		is_clear = 1'b0;
		case (command)
			CMD_CLEAR: is_clear = 1'b1;
			CMD_BLIT:  is_blit  = 1'b1;
			CMD_READ:  is_read  = 1'b1;
			default:   ;
		endcase
	end

	// Target cell: a read addresses the position itself, a blit adds the offset.
	assign col = is_read ? {sprite_x[7], sprite_x}
	                     : ({sprite_x[7], sprite_x} + {3'b000, cell_x});
	assign row = is_read ? {sprite_y[7], sprite_y}
	                     : ({sprite_y[7], sprite_y} + {3'b000, cell_y});

	// Visibility against the configured frame, capped at the store size.
	assign col_ok = !col[8] && ({1'b0, col[7:0]} < {2'b00, frame_width})
	                        && ({1'b0, col[7:0]} < 9'(MAX_FRAME_W));
	assign row_ok = !row[8] && ({1'b0, row[7:0]} < {2'b00, frame_height})
	                        && ({1'b0, row[7:0]} < 9'(MAX_FRAME_H));

	// Control word; an empty cell of a transparent sprite is keyed out.
	always_comb begin
		op.is_clear = is_clear;
		op.is_read  = is_read;
		op.vis      = col_ok && row_ok;
		op.wr_en    = is_blit && col_ok && row_ok && (is_opaque || cell_value != CELL_EMPTY);
	end

	// Row-major address; only used when the cell is visible, so it fits.
	assign addr = AW'(row[7:0]) * AW'(MAX_FRAME_W) + AW'(col[7:0]);

endmodule

>>> hw/rtl/sprite_cell_blitter.sv
// ----------------------------------------------------------------------------
// sprite_cell_blitter: sprite blit with clipping and color key
// Frame store of 2-bit cell codes with clear, blit and read commands.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the cmd channel and each gives exactly one item on the
// res channel, in order. The cfg channel writes frame_width (index 0) and
// frame_height (index 1); it is always ready. The user must write it only
// while idle; the block does not enforce this. Blit and read items are
// taken one per cycle while the result side keeps up. A blit writes the
// store at the edge it is accepted; a read issues the store read at that
// edge. The result passes the stage 1 register, then the output register.
// A clear sweeps all MAX_FRAME_W * MAX_FRAME_H cells (4096 by default),
// one cell per cycle; no command is taken during the sweep, and its result
// (written = 1) follows when the sweep ends. After reset the same sweep
// runs once before the first command is taken; registers reset to a 40 x 30
// frame. When res.ready is low the output register and one item behind it
// hold, and cmd.ready drops until the output register frees.
// ----------------------------------------------------------------------------
module sprite_cell_blitter
	import scb_pkg::*;
#(
	parameter int MAX_FRAME_W = MAX_FRAME_W_DEF,
	parameter int MAX_FRAME_H = MAX_FRAME_H_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	scb_cmd_if.sink  cmd,
	scb_res_if.source res,
	scb_cfg_if.sink  cfg
);

	localparam int DEPTH = MAX_FRAME_W * MAX_FRAME_H;
	localparam int AW    = $clog2(DEPTH);

	logic [DIM_W-1:0]  frame_width_q;
	logic [DIM_W-1:0]  frame_height_q;
	op_t               op;
	logic [AW-1:0]     addr;
	logic              in_accept;
	logic              clear_active_q;
	logic [AW-1:0]     clear_idx_q;
	logic              s1_valid_q;
	op_t               s1_op_q;
	logic              s1_move;
	logic              out_valid_q;
	logic [CELL_W-1:0] out_read_q;
	logic              out_written_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_re;
	logic [CELL_W-1:0] mem_rdata;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RESET_FRAME_W;
			frame_height_q <= RESET_FRAME_H;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_W: frame_width_q  <= cfg.data;
				REG_FRAME_H: frame_height_q <= cfg.data;
				default:     ;
			endcase
		end
	end

	// Target computation and clipping.
	scb_clip #(
		.MAX_FRAME_W (MAX_FRAME_W),
		.MAX_FRAME_H (MAX_FRAME_H),
		.AW          (AW)
	) u_clip (
		.command      (cmd.command),
		.sprite_x     (cmd.sprite_x),
		.sprite_y     (cmd.sprite_y),
		.cell_x       (cmd.cell_x),
		.cell_y       (cmd.cell_y),
		.cell_value   (cmd.cell_value),
		.is_opaque    (cmd.is_opaque),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.op           (op),
		.addr         (addr)
	);

	// Handshake: the stage register advances when the output register is free and no sweep runs.
	assign s1_move   = s1_valid_q && !clear_active_q && (!out_valid_q || res.ready);
	assign cmd.ready = !clear_active_q && (!s1_valid_q || s1_move);
	assign in_accept = cmd.valid && cmd.ready;

	// Clear sweep: runs after reset and for each clear item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_active_q <= 1'b1;
			clear_idx_q    <= '0;
		end else if (clear_active_q) begin
			if (clear_idx_q == AW'(DEPTH - 1)) begin
				clear_active_q <= 1'b0;
				clear_idx_q    <= '0;
			end else begin
				clear_idx_q <= clear_idx_q + 1'b1;
			end
		end else if (in_accept && op.is_clear) begin
			clear_active_q <= 1'b1;
		end
	end

	// Store port selection: the sweep owns the write port while it runs.
	always_comb begin
		if (clear_active_q) begin
			mem_we    = 1'b1;
			mem_waddr = clear_idx_q;
			mem_wdata = CELL_EMPTY;
		end else begin
			mem_we    = in_accept && op.wr_en;
			mem_waddr = addr;
			mem_wdata = cmd.cell_value;
		end
	end

	assign mem_re = in_accept && op.is_read && op.vis;

	scb_frame_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr),
		.rdata (mem_rdata)
	);

	// Stage 1: control word of the item whose read data is on its way.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			s1_op_q <= op;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_read_q    <= (s1_op_q.is_read && s1_op_q.vis) ? mem_rdata : CELL_EMPTY;
			out_written_q <= s1_op_q.is_clear || s1_op_q.wr_en;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.read_value = out_read_q;
	assign res.written    = out_written_q;

`ifndef NO_ASSERTIONS
	// No command is taken while the sweep owns the store.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |-> !clear_active_q)
		else $error("command item accepted during clear sweep");

	// A clear item starts the sweep at the next edge.
	a_clear_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && op.is_clear) |=> clear_active_q)
		else $error("clear item did not start the sweep");

	// The sweep counter rests at zero between sweeps.
	a_idx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_active_q |-> (clear_idx_q == '0))
		else $error("clear index not zero while idle");

	// A clear result leaves only after its sweep.
	a_clear_result_late: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_op_q.is_clear && clear_active_q) |-> !s1_move)
		else $error("clear result released during sweep");

	// A result never both reports a write and carries read data.
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_written_q && (out_read_q != CELL_EMPTY)))
		else $error("result carries both write flag and read data");
`endif

endmodule

>>> tb/tb_sprite_cell_blitter.sv
// ----------------------------------------------------------------------------
// tb_sprite_cell_blitter: self-checking bench for the sprite cell blitter
// Drives clear, blit, read and unused commands over several frame sizes. A
// frame model inside a scoreboard predicts each result, and every item taken
// from the result channel is checked in order. Both channels idle at random,
// and the result side holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_sprite_cell_blitter;
	import scb_pkg::*;

	localparam int STORE_W = MAX_FRAME_W_DEF;
	localparam int STORE_H = MAX_FRAME_H_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;
	// A clear or the reset sweep is a quiet stretch; allow several of those.
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 385;
	localparam int PHASES = 7;

	typedef struct {
		logic [1:0]        command;
		logic signed [7:0] sprite_x;
		logic signed [7:0] sprite_y;
		logic [5:0]        cell_x;
		logic [5:0]        cell_y;
		logic [CELL_W-1:0] cell_value;
		logic              is_opaque;
	} blit_cmd_t;

	typedef struct {
		logic [CELL_W-1:0] read_value;
		logic              written;
	} cell_result_t;

	// Frame model plus the queue of results still owed by the block.
	class frame_scoreboard;
		logic [CELL_W-1:0] cells [STORE_W*STORE_H];
		logic [DIM_W-1:0]  frame_w = RESET_FRAME_W;
		logic [DIM_W-1:0]  frame_h = RESET_FRAME_H;
		cell_result_t      expected_results [$];
		int                mismatches = 0;

		function new();
			foreach (cells[i]) cells[i] = CELL_EMPTY;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
			if (idx == REG_FRAME_W)
				frame_w = data;
			else if (idx == REG_FRAME_H)
				frame_h = data;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// Sizes above the store count as the store size.
		function bit on_screen(int col, int row);
			int w;
			int h;
			w = (frame_w > STORE_W) ? STORE_W : int'(frame_w);
			h = (frame_h > STORE_H) ? STORE_H : int'(frame_h);
			return col >= 0 && row >= 0 && col < w && row < h;
		endfunction

		// Apply one accepted command to the frame and queue its result.
		function void note_command(blit_cmd_t c);
			cell_result_t r;
			int col;
			int row;
			r.read_value = CELL_EMPTY;
			r.written = 1'b0;
			case (c.command)
				CMD_CLEAR: begin
					foreach (cells[i]) cells[i] = CELL_EMPTY;
					r.written = 1'b1;
				end
				CMD_BLIT: begin
					col = int'(c.sprite_x) + int'(c.cell_x);
					row = int'(c.sprite_y) + int'(c.cell_y);
					// An empty code of a transparent sprite leaves the frame alone.
					if (on_screen(col, row) && (c.is_opaque || c.cell_value != CELL_EMPTY)) begin
						cells[row*STORE_W + col] = c.cell_value;
						r.written = 1'b1;
					end
				end
				CMD_READ: begin
					col = int'(c.sprite_x);
					row = int'(c.sprite_y);
					if (on_screen(col, row))
						r.read_value = cells[row*STORE_W + col];
				end
				default: ;
			endcase
			expected_results = {expected_results, r};
		endfunction

		task report(string msg);
			if (mismatches < 40)
				$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(logic [CELL_W-1:0] read_value, logic written);
			cell_result_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result read_value %0d written %b",
					read_value, written));
				return;
			end
			want = expected_results.pop_front();
			if (read_value !== want.read_value)
				report($sformatf("read_value %0d, want %0d", read_value, want.read_value));
			if (written !== want.written)
				report($sformatf("written %b, want %b", written, want.written));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	scb_cmd_if cmd_ch ();
	scb_res_if res_ch ();
	scb_cfg_if cfg_ch ();

	sprite_cell_blitter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	frame_scoreboard scb = new();
	bit src_gaps_on = 1'b1;
	bit sink_gaps_on = 1'b1;
	int hold_off_cycles = 0;
	int quiet_cycles = 0;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one command item and wait until the block takes it.
	task automatic issue_command(logic [1:0] op, int sx, int sy, int cx, int cy, int val,
		int opq);
		blit_cmd_t c;
		int gap;
		c.command = op;
		c.sprite_x = sx[7:0];
		c.sprite_y = sy[7:0];
		c.cell_x = cx[5:0];
		c.cell_y = cy[5:0];
		c.cell_value = val[1:0];
		c.is_opaque = opq[0];
		gap = src_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c.command;
		cmd_ch.sprite_x <= c.sprite_x;
		cmd_ch.sprite_y <= c.sprite_y;
		cmd_ch.cell_x <= c.cell_x;
		cmd_ch.cell_y <= c.cell_y;
		cmd_ch.cell_value <= c.cell_value;
		cmd_ch.is_opaque <= c.is_opaque;
		@(posedge clk);
		while (cmd_ch.ready !== 1'b1) @(posedge clk);
		scb.note_command(c);
	endtask

	// Stop offering commands until every owed result has come back.
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (scb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write an unknown index first, then both frame sizes.
	task automatic program_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
		logic [CFG_IDX_W-1:0] stray_idx, logic [DIM_W-1:0] stray_data);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [DIM_W-1:0]     dat [3];
		idx = '{stray_idx, REG_FRAME_W, REG_FRAME_H};
		dat = '{stray_data, w, h};
		for (int k = 0; k < 3; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[k];
			cfg_ch.data <= dat[k];
			@(posedge clk);
			while (cfg_ch.ready !== 1'b1) @(posedge clk);
			scb.write_reg(idx[k], dat[k]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly whole sprites followed by reads over them, plus scattered reads,
	// a rare clear and fully random items.
	task automatic random_phase(int n_items, bit pause_midway);
		int w;
		int h;
		int tx;
		int ty;
		int bx;
		int by;
		int sw;
		int sh;
		int sent;
		int roll;
		int clears_left;
		int opq;
		w = (scb.frame_w > STORE_W) ? STORE_W : int'(scb.frame_w);
		h = (scb.frame_h > STORE_H) ? STORE_H : int'(scb.frame_h);
		sent = 0;
		clears_left = 1;
		while (sent < n_items) begin
			if (pause_midway && sent >= n_items / 2) begin
				wait_drained();
				pause_midway = 1'b0;
			end
			roll = $urandom_range(0, 99);
			if (roll < 65) begin
				sw = $urandom_range(1, 8);
				sh = $urandom_range(1, 6);
				tx = int'($urandom_range(0, w + 8)) - 6;
				ty = int'($urandom_range(0, h + 8)) - 6;
				// Sometimes the sprite is placed by a large cell offset.
				bx = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 64 - sw)) : 0;
				by = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 64 - sh)) : 0;
				opq = $urandom_range(0, 1);
				for (int yy = 0; yy < sh; yy++)
					for (int xx = 0; xx < sw; xx++)
						issue_command(CMD_BLIT, tx - bx, ty - by, bx + xx, by + yy,
							$urandom_range(0, 3), opq);
				sent += sw * sh;
				repeat ($urandom_range(1, 4)) begin
					issue_command(CMD_READ, tx + int'($urandom_range(0, sw)),
						ty + int'($urandom_range(0, sh)), $urandom_range(0, 63),
						$urandom_range(0, 63), $urandom_range(0, 3), $urandom_range(0, 1));
					sent++;
				end
			end else if (roll < 67 && clears_left > 0) begin
				issue_command(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 3),
					$urandom_range(0, 1));
				clears_left--;
				sent++;
			end else if (roll < 80) begin
				issue_command(CMD_READ, int'($urandom_range(0, w + 1)) - 1,
					int'($urandom_range(0, h + 1)) - 1, $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 3), $urandom_range(0, 1));
				sent++;
			end else begin
				// Fully random item; clears are kept out to bound the run time.
				issue_command(($urandom_range(0, 2) == 0) ? CMD_UNUSED :
					(($urandom_range(0, 1) == 0) ? CMD_BLIT : CMD_READ),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 3), $urandom_range(0, 1));
				sent++;
			end
		end
	endtask

	// Result side: check each taken item, then pick ready for the next edge.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				scb.check_result(res_ch.read_value, res_ch.written);
			if (hold_off_cycles > 0) begin
				// Long hold-off so that the block backs up into its input.
				res_ch.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
				res_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (sink_gaps_on && $urandom_range(0, 99) < 30) begin
				res_ch.ready <= 1'b0;
				stall_left = pick_gap();
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any item moving on any channel.
	always @(posedge clk) begin
		if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
			(res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
			(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [DIM_W-1:0] phase_w [PHASES];
		logic [DIM_W-1:0] phase_h [PHASES];
		phase_w = '{7'd64, 7'd127, 7'd8, 7'd33, 7'd64, 7'd1, 7'd20};
		phase_h = '{7'd64, 7'd100, 7'd5, 7'd64, 7'd1, 7'd64, 7'd20};
		phase_w[PHASES-1] = DIM_W'($urandom_range(1, 64));
		phase_h[PHASES-1] = DIM_W'($urandom_range(1, 64));
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_READ;
		cmd_ch.sprite_x = '0;
		cmd_ch.sprite_y = '0;
		cmd_ch.cell_x = '0;
		cmd_ch.cell_y = '0;
		cmd_ch.cell_value = CELL_EMPTY;
		cmd_ch.is_opaque = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_FRAME_W;
		cfg_ch.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// The store is swept once after reset before commands are taken.
		@(posedge clk);
		while (cmd_ch.ready !== 1'b1) @(posedge clk);

		// Directed part on the reset frame of 40 x 30.
		issue_command(CMD_READ, 0, 0, 63, 63, 3, 1);
		issue_command(CMD_BLIT, 0, 0, 0, 0, 3, 1);
		issue_command(CMD_BLIT, 0, 0, 0, 0, 0, 0);
		issue_command(CMD_READ, 0, 0, 0, 0, 0, 0);
		issue_command(CMD_BLIT, -1, 0, 1, 0, 0, 1);
		issue_command(CMD_READ, 0, 0, 0, 0, 0, 0);
		issue_command(CMD_BLIT, 39, 29, 0, 0, 2, 0);
		issue_command(CMD_BLIT, 40, 0, 0, 0, 1, 1);
		issue_command(CMD_BLIT, 0, 30, 0, 0, 1, 1);
		issue_command(CMD_BLIT, -128, -128, 63, 63, 3, 1);
		issue_command(CMD_BLIT, 127, 127, 63, 63, 3, 1);
		issue_command(CMD_BLIT, -40, -20, 63, 45, 1, 0);
		issue_command(CMD_READ, 39, 29, 0, 0, 0, 0);
		issue_command(CMD_READ, 23, 25, 63, 63, 3, 1);
		issue_command(CMD_READ, -1, 127, 0, 0, 0, 0);
		issue_command(CMD_READ, -128, -128, 63, 63, 3, 1);
		issue_command(CMD_UNUSED, -1, -1, 63, 63, 3, 1);
		issue_command(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
		issue_command(CMD_READ, 39, 29, 0, 0, 0, 0);
		wait_drained();
		// Oversized width counts as the whole store.
		program_frame(7'd127, 7'd64, REG_SPARE_LO, 7'd5);
		issue_command(CMD_BLIT, 0, 0, 63, 63, 3, 1);
		issue_command(CMD_BLIT, 1, 0, 63, 0, 2, 1);
		wait_drained();
		// Shrunk frame hides the corner; zero sizes clip everything.
		program_frame(7'd1, 7'd1, REG_SPARE_HI, 7'd127);
		issue_command(CMD_READ, 63, 63, 0, 0, 0, 0);
		issue_command(CMD_BLIT, 0, 0, 1, 0, 2, 1);
		wait_drained();
		program_frame(7'd0, 7'd64, REG_SPARE_LO, 7'd0);
		issue_command(CMD_BLIT, 0, 0, 0, 0, 3, 1);
		wait_drained();
		program_frame(7'd64, 7'd0, REG_SPARE_HI, 7'd64);
		issue_command(CMD_READ, 0, 0, 0, 0, 0, 0);
		wait_drained();
		// Growing again brings the hidden corner back.
		program_frame(7'd64, 7'd64, REG_SPARE_LO, 7'd1);
		issue_command(CMD_READ, 63, 63, 0, 0, 0, 0);

		// Random part, one frame size per phase.
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			program_frame(phase_w[p], phase_h[p], (p % 2) ? REG_SPARE_HI : REG_SPARE_LO,
				DIM_W'($urandom_range(0, 127)));
			src_gaps_on = (p != 1) && (p != 4);
			sink_gaps_on = (p != 4) && (p != 5);
			if (p == 1)
				hold_off_cycles = 200;
			random_phase(RANDOM_ITEMS / PHASES, p == 3);
		end

		wait_drained();
		if (scb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
